### hw/rtl/dllc_pkg.sv
package dllc_pkg;

  localparam int POOL_ENTRIES_DEF = 64;
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int DATA_W           = 32;
  localparam int COUNT_W          = 7;
  localparam int REQ_W            = 4;

  localparam logic [REQ_W-1:0] REQ_QUERY      = 4'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd1;
  localparam logic [REQ_W-1:0] REQ_INS_HEAD   = 4'd2;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_CUR_HEAD   = 4'd4;
  localparam logic [REQ_W-1:0] REQ_CUR_TAIL   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_DEL_HEAD   = 4'd6;
  localparam logic [REQ_W-1:0] REQ_DEL_TAIL   = 4'd7;
  localparam logic [REQ_W-1:0] REQ_DEL_AFTER  = 4'd8;
  localparam logic [REQ_W-1:0] REQ_DEL_BEFORE = 4'd9;
  localparam logic [REQ_W-1:0] REQ_INS_AFTER  = 4'd10;
  localparam logic [REQ_W-1:0] REQ_INS_BEFORE = 4'd11;
  localparam logic [REQ_W-1:0] REQ_UPDATE     = 4'd12;
  localparam logic [REQ_W-1:0] REQ_STEP_NEXT  = 4'd13;
  localparam logic [REQ_W-1:0] REQ_STEP_PREV  = 4'd14;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                     error_flag;
    logic                     cursor_valid;
    logic signed [DATA_W-1:0] cursor_value;
    logic                     head_valid;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;
    logic [COUNT_W-1:0]       item_count;
  } rsp_t;

  // datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_CUR_END,
    CMD_UPDATE,
    CMD_RD_CUR,
    CMD_STEP_SET,
    CMD_ALLOC_RD,
    CMD_ALLOC,
    CMD_ERR,
    CMD_INS_END1,
    CMD_INS_END2,
    CMD_INS_ADJ1,
    CMD_INS_ADJ2,
    CMD_DEL_END0,
    CMD_DEL_END1,
    CMD_FLIP,
    CMD_DEL_ADJ1,
    CMD_DEL_ADJ2,
    CMD_RD_HEAD,
    CMD_RD_TAIL,
    CMD_RD_CURV,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic cur_ok;
    logic front_ok;
    logic rd_ok;
    logic rd_is_back;
    logic can_alloc;
  } stat_t;

  // requests that walk the list toward the head
  function automatic logic req_dir(input logic [REQ_W-1:0] code);
    return code inside {REQ_INS_TAIL, REQ_CUR_TAIL, REQ_DEL_TAIL, REQ_DEL_BEFORE,
                        REQ_INS_BEFORE, REQ_STEP_PREV};
  endfunction

endpackage

### hw/rtl/dllc_ram.sv
module dllc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/dllc_datapath.sv
module dllc_datapath #(
  parameter int POOL_ENTRIES = dllc_pkg::POOL_ENTRIES_DEF,
  parameter int VALUE_WIDTH  = dllc_pkg::VALUE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  dllc_pkg::cmd_t cmd,
  input  dllc_pkg::req_t req,
  output dllc_pkg::stat_t stat,
  output dllc_pkg::rsp_t result
);

  localparam int PW = $clog2(POOL_ENTRIES + 1);
  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int VW = VALUE_WIDTH;
  localparam int DW = dllc_pkg::DATA_W;
  localparam int CW = dllc_pkg::COUNT_W;
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

  logic [PW-1:0] head, tail, cur, free_top, fresh, used;
  logic [PW-1:0] a, y, n;
  logic          dir, err;
  logic [VW-1:0] vin, hv, tv;

  logic [PW-1:0] front, back, frd;
  logic [VW+DW-1:0] vin_ext;

  // forward/backward link ports, mapped onto next/prev by dir
  logic          f_we, b_we, link_re;
  logic [AW-1:0] f_addr, b_addr, link_raddr;
  logic [PW-1:0] f_data, b_data;
  logic          val_we, val_re;
  logic [AW-1:0] val_waddr, val_raddr;
  logic [VW-1:0] val_wdata, val_rdata;
  logic          fr_we, fr_re;
  logic [AW-1:0] fr_waddr, fr_raddr, fr_wdata, fr_rdata;
  logic [PW-1:0] next_rdata, prev_rdata;

  logic [VW+DW-1:0] cv_ext, hv_ext, tv_ext;
  logic [PW+CW-1:0] cnt_ext;

  assign front = dir ? tail : head;
  assign back  = dir ? head : tail;
  assign frd   = dir ? prev_rdata : next_rdata;
  assign vin_ext = {{VW{1'b0}}, req.value_in};

  assign stat.cur_ok     = cur < NIL;
  assign stat.front_ok   = front < NIL;
  assign stat.rd_ok      = frd < NIL;
  assign stat.rd_is_back = frd == back;
  assign stat.can_alloc  = (free_top != '0) || (fresh < NIL);

  always_comb begin
    f_we = 1'b0; f_addr = '0; f_data = '0;
    b_we = 1'b0; b_addr = '0; b_data = '0;
    link_re = 1'b0; link_raddr = '0;
    val_we = 1'b0; val_waddr = '0; val_wdata = '0;
    val_re = 1'b0; val_raddr = '0;
    fr_we = 1'b0; fr_waddr = free_top[AW-1:0]; fr_wdata = a[AW-1:0];
    fr_re = 1'b0; fr_raddr = '0;
    case (cmd)
      dllc_pkg::CMD_UPDATE: begin
        val_we = 1'b1; val_waddr = cur[AW-1:0]; val_wdata = vin;
      end
      dllc_pkg::CMD_RD_CUR: begin
        link_re = 1'b1; link_raddr = cur[AW-1:0];
      end
      dllc_pkg::CMD_ALLOC_RD: begin
        fr_re = 1'b1;
        fr_raddr = AW'(free_top - PW'(1));
      end
      dllc_pkg::CMD_INS_END1: begin
        val_we = 1'b1; val_waddr = n[AW-1:0]; val_wdata = vin;
        b_we = 1'b1; b_addr = n[AW-1:0]; b_data = NIL;
        f_we = 1'b1; f_addr = n[AW-1:0]; f_data = front;
      end
      dllc_pkg::CMD_INS_END2: begin
        b_we = front < NIL; b_addr = front[AW-1:0]; b_data = n;
      end
      dllc_pkg::CMD_INS_ADJ1: begin
        val_we = 1'b1; val_waddr = n[AW-1:0]; val_wdata = vin;
        b_we = 1'b1; b_addr = n[AW-1:0]; b_data = cur;
        f_we = 1'b1; f_addr = n[AW-1:0]; f_data = frd;
      end
      dllc_pkg::CMD_INS_ADJ2: begin
        f_we = 1'b1; f_addr = cur[AW-1:0]; f_data = n;
        b_we = y < NIL; b_addr = y[AW-1:0]; b_data = n;
      end
      dllc_pkg::CMD_DEL_END0: begin
        link_re = 1'b1; link_raddr = front[AW-1:0];
      end
      dllc_pkg::CMD_DEL_END1: begin
        fr_we = free_top < NIL;
        b_we = frd < NIL; b_addr = frd[AW-1:0]; b_data = NIL;
      end
      dllc_pkg::CMD_DEL_ADJ1: begin
        link_re = 1'b1; link_raddr = frd[AW-1:0];
      end
      dllc_pkg::CMD_DEL_ADJ2: begin
        fr_we = free_top < NIL;
        f_we = 1'b1; f_addr = cur[AW-1:0]; f_data = frd;
        b_we = frd < NIL; b_addr = frd[AW-1:0]; b_data = cur;
      end
      dllc_pkg::CMD_RD_HEAD: begin
        val_re = 1'b1; val_raddr = head[AW-1:0];
      end
      dllc_pkg::CMD_RD_TAIL: begin
        val_re = 1'b1; val_raddr = tail[AW-1:0];
      end
      dllc_pkg::CMD_RD_CURV: begin
        val_re = 1'b1; val_raddr = cur[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  dllc_ram #(.WIDTH(VW), .DEPTH(POOL_ENTRIES)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .re(val_re), .raddr(val_raddr), .rdata(val_rdata)
  );

  dllc_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_next_ram (
    .clk(clk), .we(dir ? b_we : f_we), .waddr(dir ? b_addr : f_addr),
    .wdata(dir ? b_data : f_data), .re(link_re), .raddr(link_raddr),
    .rdata(next_rdata)
  );

  dllc_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_prev_ram (
    .clk(clk), .we(dir ? f_we : b_we), .waddr(dir ? f_addr : b_addr),
    .wdata(dir ? f_data : b_data), .re(link_re), .raddr(link_raddr),
    .rdata(prev_rdata)
  );

  dllc_ram #(.WIDTH(AW), .DEPTH(POOL_ENTRIES)) u_free_ram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .re(fr_re), .raddr(fr_raddr), .rdata(fr_rdata)
  );

  assign cv_ext  = {{DW{1'b0}}, val_rdata};
  assign hv_ext  = {{DW{1'b0}}, hv};
  assign tv_ext  = {{DW{1'b0}}, tv};
  assign cnt_ext = {{CW{1'b0}}, used};

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= NIL;
      tail <= NIL;
      cur <= NIL;
      free_top <= '0;
      fresh <= '0;
      used <= '0;
      dir <= 1'b0;
      err <= 1'b0;
    end else begin
      case (cmd)
        dllc_pkg::CMD_LOAD: begin
          vin <= vin_ext[VW-1:0];
          dir <= dllc_pkg::req_dir(req.req_type);
          err <= 1'b0;
        end
        dllc_pkg::CMD_CLEAR: begin
          head <= NIL;
          tail <= NIL;
          cur <= NIL;
          free_top <= '0;
          fresh <= '0;
          used <= '0;
        end
        dllc_pkg::CMD_CUR_END: cur <= front;
        dllc_pkg::CMD_STEP_SET: cur <= frd;
        dllc_pkg::CMD_ALLOC: begin
          if (free_top != '0) begin
            n <= PW'(fr_rdata);
            free_top <= free_top - PW'(1);
          end else begin
            n <= fresh;
            fresh <= fresh + PW'(1);
          end
          used <= used + PW'(1);
        end
        dllc_pkg::CMD_ERR: err <= 1'b1;
        dllc_pkg::CMD_INS_END2: begin
          if (dir) tail <= n;
          else head <= n;
          if (!(front < NIL)) begin
            if (dir) head <= n;
            else tail <= n;
          end
        end
        dllc_pkg::CMD_INS_ADJ1: y <= frd;
        dllc_pkg::CMD_INS_ADJ2: begin
          if (!(y < NIL)) begin
            if (dir) head <= n;
            else tail <= n;
          end
        end
        dllc_pkg::CMD_DEL_END0: begin
          a <= front;
          if (cur == front) cur <= NIL;
        end
        dllc_pkg::CMD_DEL_END1: begin
          if (dir) tail <= frd;
          else head <= frd;
          if (!(frd < NIL)) begin
            if (dir) head <= NIL;
            else tail <= NIL;
          end
          if (free_top < NIL) free_top <= free_top + PW'(1);
          if (used != '0) used <= used - PW'(1);
        end
        dllc_pkg::CMD_FLIP: dir <= ~dir;
        dllc_pkg::CMD_DEL_ADJ1: a <= frd;
        dllc_pkg::CMD_DEL_ADJ2: begin
          if (free_top < NIL) free_top <= free_top + PW'(1);
          if (used != '0) used <= used - PW'(1);
        end
        dllc_pkg::CMD_RD_TAIL: hv <= val_rdata;
        dllc_pkg::CMD_RD_CURV: tv <= val_rdata;
        dllc_pkg::CMD_OUT: begin
          result.error_flag   <= err;
          result.cursor_valid <= cur < NIL;
          result.cursor_value <= (cur < NIL) ? cv_ext[DW-1:0] : '0;
          result.head_valid   <= head < NIL;
          result.head_value   <= (head < NIL) ? hv_ext[DW-1:0] : '0;
          result.tail_value   <= (tail < NIL) ? tv_ext[DW-1:0] : '0;
          result.item_count   <= cnt_ext[CW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // every node handed out is either in the list or back on the free stack
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, free_top} + {1'b0, used}) == {1'b0, fresh})
    else $error("pool accounting out of balance");

  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    (head < NIL) == (tail < NIL))
    else $error("head and tail validity disagree");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    (cur < NIL) |-> (head < NIL))
    else $error("cursor valid on an empty list");

endmodule

### hw/rtl/dllc_ctrl.sv
module dllc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dllc_pkg::REQ_W-1:0] req_type,
  input  dllc_pkg::stat_t            stat,
  output dllc_pkg::cmd_t             cmd,
  output logic                       busy,
  output logic                       done
);

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_CUR_END, S_UPDATE, S_STEP_RD, S_STEP_SET,
    S_ALLOC_RD, S_ALLOC, S_INS_END1, S_INS_END2, S_INS_ADJ_RD, S_INS_ADJ1,
    S_INS_ADJ2, S_DEL_END0, S_DEL_END1, S_DEL_ADJ_RD, S_DEL_ADJ1, S_DEL_ADJ2,
    S_RD_HEAD, S_RD_TAIL, S_RD_CURV, S_OUT
  } state_t;

  state_t state, state_next;
  logic [dllc_pkg::REQ_W-1:0] op;
  logic ins_end;

  assign busy = state != S_IDLE;
  assign ins_end = (op == dllc_pkg::REQ_INS_HEAD) || (op == dllc_pkg::REQ_INS_TAIL);

  always_comb begin
    cmd = dllc_pkg::CMD_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd = dllc_pkg::CMD_LOAD;
          case (req_type)
            dllc_pkg::REQ_CLEAR: state_next = S_CLEAR;
            dllc_pkg::REQ_INS_HEAD, dllc_pkg::REQ_INS_TAIL: state_next = S_ALLOC_RD;
            dllc_pkg::REQ_CUR_HEAD, dllc_pkg::REQ_CUR_TAIL: state_next = S_CUR_END;
            dllc_pkg::REQ_DEL_HEAD, dllc_pkg::REQ_DEL_TAIL: state_next = S_DEL_END0;
            dllc_pkg::REQ_DEL_AFTER, dllc_pkg::REQ_DEL_BEFORE:
              state_next = stat.cur_ok ? S_DEL_ADJ_RD : S_RD_HEAD;
            dllc_pkg::REQ_INS_AFTER, dllc_pkg::REQ_INS_BEFORE:
              state_next = stat.cur_ok ? S_ALLOC_RD : S_RD_HEAD;
            dllc_pkg::REQ_UPDATE:
              state_next = stat.cur_ok ? S_UPDATE : S_RD_HEAD;
            dllc_pkg::REQ_STEP_NEXT, dllc_pkg::REQ_STEP_PREV:
              state_next = stat.cur_ok ? S_STEP_RD : S_RD_HEAD;
            default: state_next = S_RD_HEAD;
          endcase
        end
      end
      S_CLEAR: begin
        cmd = dllc_pkg::CMD_CLEAR;
        state_next = S_RD_HEAD;
      end
      S_CUR_END: begin
        cmd = dllc_pkg::CMD_CUR_END;
        state_next = S_RD_HEAD;
      end
      S_UPDATE: begin
        cmd = dllc_pkg::CMD_UPDATE;
        state_next = S_RD_HEAD;
      end
      S_STEP_RD: begin
        cmd = dllc_pkg::CMD_RD_CUR;
        state_next = S_STEP_SET;
      end
      S_STEP_SET: begin
        cmd = dllc_pkg::CMD_STEP_SET;
        state_next = S_RD_HEAD;
      end
      S_ALLOC_RD: begin
        if (stat.can_alloc) begin
          cmd = dllc_pkg::CMD_ALLOC_RD;
          state_next = S_ALLOC;
        end else begin
          cmd = dllc_pkg::CMD_ERR;
          state_next = S_RD_HEAD;
        end
      end
      S_ALLOC: begin
        cmd = dllc_pkg::CMD_ALLOC;
        state_next = ins_end ? S_INS_END1 : S_INS_ADJ_RD;
      end
      S_INS_END1: begin
        cmd = dllc_pkg::CMD_INS_END1;
        state_next = S_INS_END2;
      end
      S_INS_END2: begin
        cmd = dllc_pkg::CMD_INS_END2;
        state_next = S_RD_HEAD;
      end
      S_INS_ADJ_RD: begin
        cmd = dllc_pkg::CMD_RD_CUR;
        state_next = S_INS_ADJ1;
      end
      S_INS_ADJ1: begin
        cmd = dllc_pkg::CMD_INS_ADJ1;
        state_next = S_INS_ADJ2;
      end
      S_INS_ADJ2: begin
        cmd = dllc_pkg::CMD_INS_ADJ2;
        state_next = S_RD_HEAD;
      end
      S_DEL_END0: begin
        if (stat.front_ok) begin
          cmd = dllc_pkg::CMD_DEL_END0;
          state_next = S_DEL_END1;
        end else begin
          state_next = S_RD_HEAD;
        end
      end
      S_DEL_END1: begin
        cmd = dllc_pkg::CMD_DEL_END1;
        state_next = S_RD_HEAD;
      end
      S_DEL_ADJ_RD: begin
        cmd = dllc_pkg::CMD_RD_CUR;
        state_next = S_DEL_ADJ1;
      end
      S_DEL_ADJ1: begin
        if (!stat.rd_ok) begin
          state_next = S_RD_HEAD;
        end else if (stat.rd_is_back) begin
          // neighbor is the far end: becomes a delete at that end
          cmd = dllc_pkg::CMD_FLIP;
          state_next = S_DEL_END0;
        end else begin
          cmd = dllc_pkg::CMD_DEL_ADJ1;
          state_next = S_DEL_ADJ2;
        end
      end
      S_DEL_ADJ2: begin
        cmd = dllc_pkg::CMD_DEL_ADJ2;
        state_next = S_RD_HEAD;
      end
      S_RD_HEAD: begin
        cmd = dllc_pkg::CMD_RD_HEAD;
        state_next = S_RD_TAIL;
      end
      S_RD_TAIL: begin
        cmd = dllc_pkg::CMD_RD_TAIL;
        state_next = S_RD_CURV;
      end
      S_RD_CURV: begin
        cmd = dllc_pkg::CMD_RD_CURV;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd = dllc_pkg::CMD_OUT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= state == S_OUT;
      if (state == S_IDLE && start) op <= req_type;
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_out_strobe: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> (done && !busy))
    else $error("result not presented after output step");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

endmodule

### hw/rtl/doubly_linked_list_cursor_engine.sv
// the result strobe follows the dependent link reads/writes in the pool memories and then
// a value readout through the RD_HEAD, RD_TAIL, RD_CURV and OUT states
// one request at a time, taken while busy is low; start may be taken in the cycle done is high
// reset (rst, synchronous): list empty, cursor invalid, pool fully free
// the result is shown for one cycle with done; the receiver cannot stall
module doubly_linked_list_cursor_engine #(
  parameter int POOL_ENTRIES = dllc_pkg::POOL_ENTRIES_DEF,
  parameter int VALUE_WIDTH  = dllc_pkg::VALUE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dllc_pkg::req_t req,
  output logic           done,
  output dllc_pkg::rsp_t result
);

  dllc_pkg::cmd_t  cmd;
  dllc_pkg::stat_t stat;

  dllc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req.req_type),
    .stat(stat), .cmd(cmd), .busy(busy), .done(done)
  );

  dllc_datapath #(
    .POOL_ENTRIES(POOL_ENTRIES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .req(req), .stat(stat), .result(result)
  );

endmodule

### tb/doubly_linked_list_cursor_engine_tb.sv
module doubly_linked_list_cursor_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 64;
  localparam logic [6:0] NIL = 7'd64;
  localparam int WATCHDOG = 2000;

  logic clk, rst, start, busy, done;
  dllc_pkg::req_t req;
  dllc_pkg::rsp_t result;

  doubly_linked_list_cursor_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // shadow copy of the list
  logic [31:0] lst_val [NODES];
  logic [6:0]  lst_next [NODES];
  logic [6:0]  lst_prev [NODES];
  logic [6:0]  free_stk [NODES];
  logic [6:0]  head_p, tail_p, cur_p, free_top, fresh, used;

  dllc_pkg::rsp_t pending_rsp [$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   n_sent = 0, n_rcvd = 0, n_full = 0;

  function automatic bit is_node(logic [6:0] p);
    return p < NIL;
  endfunction

  function automatic void list_clear();
    head_p = NIL; tail_p = NIL; cur_p = NIL;
    free_top = 0; fresh = 0; used = 0;
  endfunction

  function automatic logic [6:0] node_take();
    logic [6:0] n;
    n = NIL;
    if (free_top > 0) begin
      free_top--;
      n = free_stk[free_top];
    end else if (fresh < NIL) begin
      n = fresh;
      fresh++;
    end
    if (is_node(n)) used++;
    return n;
  endfunction

  function automatic void node_give(logic [6:0] n);
    if (!is_node(n)) return;
    if (free_top < NIL) begin
      free_stk[free_top] = n;
      free_top++;
    end
    if (used > 0) used--;
  endfunction

  function automatic void drop_head();
    logic [6:0] h, nx;
    h = head_p;
    if (!is_node(h)) return;
    if (cur_p == h) cur_p = NIL;
    nx = lst_next[h];
    node_give(h);
    head_p = nx;
    if (is_node(nx)) lst_prev[nx] = NIL; else tail_p = NIL;
  endfunction

  function automatic void drop_tail();
    logic [6:0] t, pv;
    t = tail_p;
    if (!is_node(t)) return;
    if (cur_p == t) cur_p = NIL;
    pv = lst_prev[t];
    node_give(t);
    tail_p = pv;
    if (is_node(pv)) lst_next[pv] = NIL; else head_p = NIL;
  endfunction

  function automatic dllc_pkg::rsp_t list_apply(dllc_pkg::req_t r);
    logic [6:0] c, n, x;
    logic [31:0] v;
    dllc_pkg::rsp_t o;
    bit err;
    c = cur_p; v = r.value_in; err = 0;
    case (r.req_type)
      dllc_pkg::REQ_CLEAR: list_clear();
      dllc_pkg::REQ_INS_HEAD: begin
        n = node_take();
        if (!is_node(n)) err = 1;
        else begin
          lst_val[n] = v; lst_prev[n] = NIL; lst_next[n] = head_p;
          if (is_node(head_p)) lst_prev[head_p] = n; else tail_p = n;
          head_p = n;
        end
      end
      dllc_pkg::REQ_INS_TAIL: begin
        n = node_take();
        if (!is_node(n)) err = 1;
        else begin
          lst_val[n] = v; lst_next[n] = NIL; lst_prev[n] = tail_p;
          if (is_node(tail_p)) lst_next[tail_p] = n; else head_p = n;
          tail_p = n;
        end
      end
      dllc_pkg::REQ_CUR_HEAD: cur_p = head_p;
      dllc_pkg::REQ_CUR_TAIL: cur_p = tail_p;
      dllc_pkg::REQ_DEL_HEAD: drop_head();
      dllc_pkg::REQ_DEL_TAIL: drop_tail();
      dllc_pkg::REQ_DEL_AFTER: if (is_node(c)) begin
        x = lst_next[c];
        if (is_node(x)) begin
          if (x == tail_p) drop_tail();
          else begin
            lst_next[c] = lst_next[x];
            if (is_node(lst_next[x])) lst_prev[lst_next[x]] = c;
            node_give(x);
          end
        end
      end
      dllc_pkg::REQ_DEL_BEFORE: if (is_node(c)) begin
        x = lst_prev[c];
        if (is_node(x)) begin
          if (x == head_p) drop_head();
          else begin
            lst_prev[c] = lst_prev[x];
            if (is_node(lst_prev[x])) lst_next[lst_prev[x]] = c;
            node_give(x);
          end
        end
      end
      dllc_pkg::REQ_INS_AFTER: if (is_node(c)) begin
        n = node_take();
        if (!is_node(n)) err = 1;
        else begin
          lst_val[n] = v; lst_prev[n] = c; lst_next[n] = lst_next[c];
          lst_next[c] = n;
          if (is_node(lst_next[n])) lst_prev[lst_next[n]] = n; else tail_p = n;
        end
      end
      dllc_pkg::REQ_INS_BEFORE: if (is_node(c)) begin
        n = node_take();
        if (!is_node(n)) err = 1;
        else begin
          lst_val[n] = v; lst_next[n] = c; lst_prev[n] = lst_prev[c];
          lst_prev[c] = n;
          if (is_node(lst_prev[n])) lst_next[lst_prev[n]] = n; else head_p = n;
        end
      end
      dllc_pkg::REQ_UPDATE: if (is_node(c)) lst_val[c] = v;
      dllc_pkg::REQ_STEP_NEXT: if (is_node(c)) cur_p = lst_next[c];
      dllc_pkg::REQ_STEP_PREV: if (is_node(c)) cur_p = lst_prev[c];
      default: ;
    endcase
    if (err) n_full++;
    o.error_flag   = err;
    o.cursor_valid = is_node(cur_p);
    o.cursor_value = is_node(cur_p) ? lst_val[cur_p] : '0;
    o.head_valid   = is_node(head_p);
    o.head_value   = is_node(head_p) ? lst_val[head_p] : '0;
    o.tail_value   = is_node(tail_p) ? lst_val[tail_p] : '0;
    o.item_count   = used;
    return o;
  endfunction

  // directed rows: fixed expectation where obvious
  typedef struct {
    logic [3:0]     code;
    logic [31:0]    val;
    bit             fixed;
    dllc_pkg::rsp_t rsp;
  } row_t;

  function automatic dllc_pkg::rsp_t mk(bit e, bit cv, logic [31:0] c, bit hv,
                                        logic [31:0] h, logic [31:0] t, logic [6:0] k);
    dllc_pkg::rsp_t o;
    o.error_flag = e; o.cursor_valid = cv; o.cursor_value = c;
    o.head_valid = hv; o.head_value = h; o.tail_value = t; o.item_count = k;
    return o;
  endfunction

  row_t rows [$];

  initial begin
    rows = '{
      '{dllc_pkg::REQ_QUERY,      32'h0,        1, mk(0,0,0,0,0,0,0)},
      '{dllc_pkg::REQ_DEL_HEAD,   32'h0,        1, mk(0,0,0,0,0,0,0)},
      '{dllc_pkg::REQ_DEL_TAIL,   32'h0,        1, mk(0,0,0,0,0,0,0)},
      '{dllc_pkg::REQ_INS_AFTER,  32'h5,        1, mk(0,0,0,0,0,0,0)},
      '{dllc_pkg::REQ_INS_BEFORE, 32'h5,        1, mk(0,0,0,0,0,0,0)},
      '{dllc_pkg::REQ_STEP_NEXT,  32'h0,        1, mk(0,0,0,0,0,0,0)},
      '{dllc_pkg::REQ_UPDATE,     32'h7,        1, mk(0,0,0,0,0,0,0)},
      '{dllc_pkg::REQ_INS_HEAD,   32'h80000000, 1,
        mk(0,0,0,1,32'h80000000,32'h80000000,1)},
      '{dllc_pkg::REQ_INS_TAIL,   32'h7fffffff, 1,
        mk(0,0,0,1,32'h80000000,32'h7fffffff,2)},
      '{dllc_pkg::REQ_CUR_HEAD,   32'h0,        0, '0},
      '{dllc_pkg::REQ_INS_AFTER,  32'hffffffff, 0, '0},
      '{dllc_pkg::REQ_INS_BEFORE, 32'h0,        0, '0},
      '{dllc_pkg::REQ_STEP_NEXT,  32'h0,        0, '0},
      '{dllc_pkg::REQ_DEL_BEFORE, 32'h0,        0, '0},
      '{dllc_pkg::REQ_DEL_AFTER,  32'h0,        0, '0},
      '{dllc_pkg::REQ_UPDATE,     32'h12345678, 0, '0},
      '{dllc_pkg::REQ_STEP_PREV,  32'h0,        0, '0},
      '{dllc_pkg::REQ_CUR_TAIL,   32'h0,        0, '0},
      '{dllc_pkg::REQ_STEP_NEXT,  32'h0,        0, '0},
      '{dllc_pkg::REQ_CUR_TAIL,   32'h0,        0, '0},
      '{dllc_pkg::REQ_DEL_TAIL,   32'h0,        0, '0},
      '{4'd15,                    32'h0,        0, '0},
      '{dllc_pkg::REQ_CLEAR,      32'h0,        1, mk(0,0,0,0,0,0,0)}
    };
  end

  // result checking
  always @(posedge clk) begin
    dllc_pkg::rsp_t exp_r;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_r = pending_rsp.pop_front();
        n_rcvd++;
        if (result.error_flag !== exp_r.error_flag) begin
          $error("error_flag exp %0d got %0d", exp_r.error_flag, result.error_flag); errors++;
        end
        if (result.cursor_valid !== exp_r.cursor_valid) begin
          $error("cursor_valid exp %0d got %0d", exp_r.cursor_valid, result.cursor_valid);
          errors++;
        end
        if (result.cursor_value !== exp_r.cursor_value) begin
          $error("cursor_value exp %0d got %0d", exp_r.cursor_value, result.cursor_value);
          errors++;
        end
        if (result.head_valid !== exp_r.head_valid) begin
          $error("head_valid exp %0d got %0d", exp_r.head_valid, result.head_valid); errors++;
        end
        if (result.head_value !== exp_r.head_value) begin
          $error("head_value exp %0d got %0d", exp_r.head_value, result.head_value); errors++;
        end
        if (result.tail_value !== exp_r.tail_value) begin
          $error("tail_value exp %0d got %0d", exp_r.tail_value, result.tail_value); errors++;
        end
        if (result.item_count !== exp_r.item_count) begin
          $error("item_count exp %0d got %0d", exp_r.item_count, result.item_count); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one request transfer; fixed row expectation overrides predictor where given
  task automatic send(logic [3:0] code, logic [31:0] val, bit fixed, dllc_pkg::rsp_t fx);
    dllc_pkg::req_t r;
    dllc_pkg::rsp_t p;
    r.req_type = code;
    r.value_in = val;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    p = list_apply(r);
    pending_rsp.push_back(fixed ? fx : p);
    n_sent++;
  endtask

  task automatic gap(bit allow);
    int k;
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      k = $urandom_range(1, 16);
      repeat (k) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // biased codes: inserts dominate in fill phases so the pool gets full
  function automatic logic [3:0] pick_code(int phase);
    int w;
    w = $urandom_range(0, 99);
    if (phase == 1) begin
      if (w < 60) return (w < 20) ? dllc_pkg::REQ_INS_HEAD :
                         (w < 40) ? dllc_pkg::REQ_INS_TAIL :
                         (w < 50) ? dllc_pkg::REQ_INS_AFTER : dllc_pkg::REQ_INS_BEFORE;
    end else if (phase == 2) begin
      if (w < 45) return (w < 15) ? dllc_pkg::REQ_DEL_HEAD :
                         (w < 30) ? dllc_pkg::REQ_DEL_TAIL :
                         (w < 38) ? dllc_pkg::REQ_DEL_AFTER : dllc_pkg::REQ_DEL_BEFORE;
    end
    if (w == 99) return dllc_pkg::REQ_CLEAR;
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin
    int i, phase, t;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    list_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[j]) begin
      send(rows[j].code, rows[j].val, rows[j].fixed, rows[j].rsp);
      gap(1);
    end
    start <= 1'b0;
    // hold off until the block has answered everything
    while (pending_rsp.size() != 0) @(posedge clk);

    // fill past the pool size to hit the full-pool error
    for (i = 0; i < 70; i++) begin
      send(($urandom_range(0, 1) != 0) ? dllc_pkg::REQ_INS_HEAD : dllc_pkg::REQ_INS_TAIL,
           rand_val(), 0, '0);
      gap(1);
    end
    send(dllc_pkg::REQ_CUR_HEAD, 0, 0, '0);
    send(dllc_pkg::REQ_INS_AFTER, rand_val(), 0, '0);
    send(dllc_pkg::REQ_INS_BEFORE, rand_val(), 0, '0);

    for (i = 0; i < 860; i++) begin
      phase = (i / 60) % 3;
      t = pick_code(phase);
      send(t[3:0], rand_val(), 0, '0);
      gap(i < 760);
    end
    start <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d requests, checked %0d results, %0d full-pool rejects",
             n_sent, n_rcvd, n_full);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
